@@ hw/rtl/mtep_pkg.sv @@
`default_nettype none
package mtep_pkg;

	localparam int DELTA_BITS_DEF = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] KIND_CHANNEL = 2'd0;
	localparam logic [1:0] KIND_TEMPO = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;

	localparam logic [7:0] DATA_MASK = 8'h7f;
	localparam logic [7:0] STATUS_BIT = 8'h80;
	localparam logic [7:0] META_STATUS = 8'hff;
	localparam logic [7:0] SYSEX_START = 8'hf0;
	localparam logic [7:0] SYSEX_ESCAPE = 8'hf7;
	localparam logic [7:0] META_END = 8'h2f;
	localparam logic [7:0] META_TEMPO = 8'h51;
	localparam logic [7:0] TEMPO_LEN = 8'h03;
	localparam logic [3:0] NIB_PROGRAM = 4'hc;
	localparam logic [3:0] NIB_PRESSURE = 4'hd;
	localparam logic [3:0] NIB_SYSTEM = 4'hf;

	typedef struct packed {
		logic [7:0] data;
		logic       sot;
		logic       is_data;
		logic       is_meta;
		logic       is_sysex;
		logic       is_system;
		logic       is_end_type;
		logic       is_tempo_type;
		logic       is_len3;
		logic       is_zero;
	} class_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] delta_ticks;
		logic [7:0]  status_byte;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [23:0] tempo_usec;
	} result_t;

	function automatic logic [31:0] vlq_push(input logic [31:0] acc, input logic [7:0] b,
		input logic [31:0] limit);
		logic [7:0] low;
		low = b & DATA_MASK;
		if (acc > (limit >> 7)) begin
			return limit;
		end
		return {acc[24:0], low[6:0]};
	endfunction

	function automatic logic one_data(input logic [7:0] st);
		return (st[7:4] == NIB_PROGRAM) || (st[7:4] == NIB_PRESSURE);
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mtep_fifo.sv @@
`default_nettype none
module mtep_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mtep_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/mtep_front.sv @@
`default_nettype none
module mtep_front #(
	parameter int DEPTH = mtep_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] data_byte,
	input  wire logic       start_of_track,
	output logic            full,
	output mtep_pkg::class_t item,
	output logic            item_valid,
	input  wire logic       item_pop
);

	mtep_pkg::class_t cls;
	logic             item_empty;

	always_comb begin
		cls.data = data_byte;
		cls.sot = start_of_track;
		cls.is_data = (data_byte & mtep_pkg::STATUS_BIT) == 8'h00;
		cls.is_meta = data_byte == mtep_pkg::META_STATUS;
		cls.is_sysex = (data_byte == mtep_pkg::SYSEX_START)
			|| (data_byte == mtep_pkg::SYSEX_ESCAPE);
		cls.is_system = data_byte[7:4] == mtep_pkg::NIB_SYSTEM;
		cls.is_end_type = data_byte == mtep_pkg::META_END;
		cls.is_tempo_type = data_byte == mtep_pkg::META_TEMPO;
		cls.is_len3 = data_byte == mtep_pkg::TEMPO_LEN;
		cls.is_zero = data_byte == 8'h00;
	end

	mtep_fifo #(
		.WIDTH($bits(mtep_pkg::class_t)),
		.DEPTH(DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cls),
		.full  (full),
		.pop   (item_pop),
		.rdata (item),
		.empty (item_empty)
	);

	assign item_valid = !item_empty;

endmodule
`default_nettype wire

@@ hw/rtl/mtep_back.sv @@
`default_nettype none
module mtep_back #(
	parameter int DELTA_BITS = mtep_pkg::DELTA_BITS_DEF,
	parameter int DEPTH = mtep_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mtep_pkg::class_t item,
	input  wire logic             item_valid,
	output logic                  item_pop,
	output logic                  empty,
	input  wire logic             pop,
	output logic [1:0]            kind,
	output logic [31:0]           delta_ticks,
	output logic [7:0]            status_byte,
	output logic [7:0]            first_data,
	output logic [7:0]            second_data,
	output logic [23:0]           tempo_usec
);

	localparam logic [31:0] DELTA_MAX = 32'hffffffff >> (32 - DELTA_BITS);

	typedef enum logic [3:0] {
		PH_DELTA,
		PH_STATUS,
		PH_DATA1,
		PH_DATA2,
		PH_META_TYPE,
		PH_META_LEN,
		PH_SKIP,
		PH_SYSEX_LEN,
		PH_DONE
	} phase_t;

	phase_t                phase_q, ph, ph_n;
	logic [DELTA_BITS-1:0] dsum_q, ds, ds_n;
	logic [7:0]            rstat_q, rs, rs_n;
	logic [7:0]            held_q, hd, hd_n;
	logic                  ttype_q, tt, tt_n;
	logic [31:0]           skip_q, sk, sk_n;
	logic [23:0]           tempo_q, tp, tp_n;
	logic                  bidx_q, bi, bi_n;

	logic [31:0]           acc;
	logic [32:0]           sum;
	logic [31:0]           sk_dec;
	logic [23:0]           tp_shift;
	logic                  emit;
	mtep_pkg::result_t     res;
	logic                  out_full;
	logic                  go;

	assign go = item_valid && !out_full;
	assign item_pop = go;

	always_comb begin
		ph = item.sot ? PH_DELTA : phase_q;
		ds = item.sot ? '0 : dsum_q;
		rs = item.sot ? '0 : rstat_q;
		hd = item.sot ? '0 : held_q;
		tt = item.sot ? 1'b0 : ttype_q;
		sk = item.sot ? '0 : skip_q;
		tp = item.sot ? '0 : tempo_q;
		bi = item.sot ? 1'b0 : bidx_q;

		ph_n = ph;
		ds_n = ds;
		rs_n = rs;
		hd_n = hd;
		tt_n = tt;
		sk_n = sk;
		tp_n = tp;
		bi_n = bi;
		emit = 1'b0;
		res = '0;
		res.delta_ticks = 32'(ds);
		acc = '0;
		sum = '0;
		sk_dec = '0;
		tp_shift = {tp[15:0], item.data};

		unique case (ph)
			PH_DELTA: begin
				acc = mtep_pkg::vlq_push(sk, item.data, DELTA_MAX);
				sum = {1'b0, 32'(ds)} + {1'b0, acc};
				if (item.is_data) begin
					ds_n = (sum > {1'b0, DELTA_MAX}) ? DELTA_BITS'(DELTA_MAX)
						: DELTA_BITS'(sum[31:0]);
					sk_n = '0;
					ph_n = PH_STATUS;
				end else begin
					sk_n = acc;
				end
			end
			PH_STATUS: begin
				if (item.is_data) begin
					hd_n = item.data;
					if (mtep_pkg::one_data(rs)) begin
						emit = 1'b1;
						res.kind = mtep_pkg::KIND_CHANNEL;
						res.status_byte = rs;
						res.first_data = item.data;
					end else begin
						ph_n = PH_DATA2;
					end
				end else if (item.is_meta) begin
					ph_n = PH_META_TYPE;
				end else if (item.is_sysex) begin
					sk_n = '0;
					ph_n = PH_SYSEX_LEN;
				end else if (item.is_system) begin
					ph_n = PH_DELTA;
				end else begin
					rs_n = item.data;
					ph_n = PH_DATA1;
				end
			end
			PH_DATA1: begin
				hd_n = item.data;
				if (mtep_pkg::one_data(rs)) begin
					emit = 1'b1;
					res.kind = mtep_pkg::KIND_CHANNEL;
					res.status_byte = rs;
					res.first_data = item.data;
				end else begin
					ph_n = PH_DATA2;
				end
			end
			PH_DATA2: begin
				emit = 1'b1;
				res.kind = mtep_pkg::KIND_CHANNEL;
				res.status_byte = rs;
				res.first_data = hd;
				res.second_data = item.data;
			end
			PH_META_TYPE: begin
				tt_n = item.is_tempo_type;
				if (item.is_end_type) begin
					emit = 1'b1;
					res.kind = mtep_pkg::KIND_END;
				end else begin
					ph_n = PH_META_LEN;
				end
			end
			PH_META_LEN: begin
				bi_n = tt && item.is_len3;
				tp_n = '0;
				sk_n = 32'(item.data);
				ph_n = item.is_zero ? PH_DELTA : PH_SKIP;
			end
			PH_SKIP: begin
				sk_dec = (sk != '0) ? sk - 1'b1 : sk;
				sk_n = sk_dec;
				if (bi) begin
					tp_n = tp_shift;
				end
				if (sk_dec == '0) begin
					if (bi) begin
						bi_n = 1'b0;
						emit = 1'b1;
						res.kind = mtep_pkg::KIND_TEMPO;
						res.tempo_usec = tp_shift;
					end else begin
						ph_n = PH_DELTA;
					end
				end
			end
			PH_SYSEX_LEN: begin
				acc = mtep_pkg::vlq_push(sk, item.data, 32'hffffffff);
				sk_n = acc;
				if (item.is_data) begin
					bi_n = 1'b0;
					ph_n = (acc == '0) ? PH_DELTA : PH_SKIP;
				end
			end
			PH_DONE: begin
			end
			default: begin
				ph_n = PH_DELTA;
			end
		endcase

		if (emit) begin
			ds_n = '0;
			ph_n = item.is_end_type && (ph == PH_META_TYPE) ? PH_DONE : PH_DELTA;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			dsum_q <= '0;
			rstat_q <= '0;
			held_q <= '0;
			ttype_q <= 1'b0;
			skip_q <= '0;
			tempo_q <= '0;
			bidx_q <= 1'b0;
		end else if (go) begin
			phase_q <= ph_n;
			dsum_q <= ds_n;
			rstat_q <= rs_n;
			held_q <= hd_n;
			ttype_q <= tt_n;
			skip_q <= sk_n;
			tempo_q <= tp_n;
			bidx_q <= bi_n;
		end
	end

	mtep_pkg::result_t head;

	mtep_fifo #(
		.WIDTH($bits(mtep_pkg::result_t)),
		.DEPTH(DEPTH)
	) u_results (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (go && emit),
		.wdata (res),
		.full  (out_full),
		.pop   (pop),
		.rdata (head),
		.empty (empty)
	);

	assign kind = head.kind;
	assign delta_ticks = head.delta_ticks;
	assign status_byte = head.status_byte;
	assign first_data = head.first_data;
	assign second_data = head.second_data;
	assign tempo_usec = head.tempo_usec;

endmodule
`default_nettype wire

@@ hw/rtl/midi_track_event_parser.sv @@
`default_nettype none
// A byte is registered in the byte queue, then any result it completes in the result queue.
// Throughput: one byte per cycle while the result queue is not full, through the combinational
// parse step between the byte queue and the result queue; each queue holds QUEUE_DEPTH items.
// Reset: arst_n empties both queues and returns the parser to waiting for a delta time.
// start_of_track on a byte clears the parse state before that byte is parsed.
module midi_track_event_parser #(
	parameter int DELTA_BITS = mtep_pkg::DELTA_BITS_DEF,
	parameter int QUEUE_DEPTH = mtep_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_of_track,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       kind,
	output logic [31:0]      delta_ticks,
	output logic [7:0]       status_byte,
	output logic [7:0]       first_data,
	output logic [7:0]       second_data,
	output logic [23:0]      tempo_usec
);

	mtep_pkg::class_t item;
	logic             item_valid;
	logic             item_pop;

	mtep_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.data_byte     (data_byte),
		.start_of_track(start_of_track),
		.full          (full),
		.item          (item),
		.item_valid    (item_valid),
		.item_pop      (item_pop)
	);

	mtep_back #(
		.DELTA_BITS(DELTA_BITS),
		.DEPTH     (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.empty      (empty),
		.pop        (pop),
		.kind       (kind),
		.delta_ticks(delta_ticks),
		.status_byte(status_byte),
		.first_data (first_data),
		.second_data(second_data),
		.tempo_usec (tempo_usec)
	);

endmodule
`default_nettype wire

@@ hw/rtl/mtep_checker.sv @@
`default_nettype none
module mtep_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [1:0]  kind,
	input wire logic [31:0] delta_ticks,
	input wire logic [7:0]  status_byte,
	input wire logic [7:0]  first_data,
	input wire logic [7:0]  second_data,
	input wire logic [23:0] tempo_usec
);

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (kind == mtep_pkg::KIND_CHANNEL || kind == mtep_pkg::KIND_TEMPO
			|| kind == mtep_pkg::KIND_END))
		else $error("result kind out of range");

	a_meta_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != mtep_pkg::KIND_CHANNEL) |->
			(status_byte == 8'h00 && first_data == 8'h00 && second_data == 8'h00))
		else $error("non-channel item carries message bytes");

	a_tempo_only: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != mtep_pkg::KIND_TEMPO) |-> tempo_usec == 24'h0)
		else $error("non-tempo item carries a tempo");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(delta_ticks)))
		else $error("waiting item changed before pop");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (.*);
`default_nettype wire
